// File: rtl/core/complex_arith_unit_top_assert.svh
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    op_t                kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               div_zero;
    logic               overflow;
  } out_t;

  typedef struct packed {
    op_t                kind;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic signed [63:0] p_bbr;
    logic signed [63:0] p_bbi;
    logic signed [32:0] s_re;
    logic signed [32:0] s_im;
  } prod_t;

  typedef struct packed {
    op_t                kind;
    logic signed [64:0] x_re;
    logic signed [64:0] x_im;
    logic        [63:0] den;
  } sum_t;

  typedef struct packed {
    logic        div;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        big_re;
    logic        big_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] den;
  } mid_t;

endpackage

// File: rtl/core/cau_prod.sv
`timescale 1ns / 1ps

module cau_prod (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  cau_pkg::in_t   up_word,
  output logic           dn_valid,
  input  logic           dn_stall,
  output cau_pkg::prod_t dn_word
);

  logic           v_r;
  cau_pkg::prod_t w_r;
  cau_pkg::prod_t w_nxt;

  assign up_stall = v_r && dn_stall;
  assign dn_valid = v_r;
  assign dn_word  = w_r;

  always_comb begin
    w_nxt.kind  = up_word.kind;
    w_nxt.p_rr  = 64'(up_word.a_re) * 64'(up_word.b_re);
    w_nxt.p_ii  = 64'(up_word.a_im) * 64'(up_word.b_im);
    w_nxt.p_ri  = 64'(up_word.a_re) * 64'(up_word.b_im);
    w_nxt.p_ir  = 64'(up_word.a_im) * 64'(up_word.b_re);
    w_nxt.p_bbr = 64'(up_word.b_re) * 64'(up_word.b_re);
    w_nxt.p_bbi = 64'(up_word.b_im) * 64'(up_word.b_im);
    if (up_word.kind == cau_pkg::OP_SUB) begin
      w_nxt.s_re = 33'(up_word.a_re) - 33'(up_word.b_re);
      w_nxt.s_im = 33'(up_word.a_im) - 33'(up_word.b_im);
    end else begin
      w_nxt.s_re = 33'(up_word.a_re) + 33'(up_word.b_re);
      w_nxt.s_im = 33'(up_word.a_im) + 33'(up_word.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!up_stall) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      w_r <= w_nxt;
    end
  end

endmodule

// File: rtl/core/cau_combine.sv
`timescale 1ns / 1ps

module cau_combine #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  cau_pkg::prod_t up_word,
  output logic           dn_valid,
  input  logic           dn_stall,
  output cau_pkg::mid_t  dn_word
);

  localparam logic [63:0] RND = 64'd1 << (FRAC_BITS - 1);

  logic          va_r;
  logic          vb_r;
  logic          stl_a;
  logic          stl_b;
  cau_pkg::sum_t a_r;
  cau_pkg::sum_t a_nxt;
  cau_pkg::mid_t b_r;
  cau_pkg::mid_t b_nxt;
  logic [64:0]   abs_re;
  logic [64:0]   abs_im;
  logic [63:0]   rnd_re;
  logic [63:0]   rnd_im;

  assign stl_b    = vb_r && dn_stall;
  assign stl_a    = va_r && stl_b;
  assign up_stall = stl_a;
  assign dn_valid = vb_r;
  assign dn_word  = b_r;

  always_comb begin
    a_nxt.kind = up_word.kind;
    a_nxt.den  = $unsigned(up_word.p_bbr) + $unsigned(up_word.p_bbi);
    case (up_word.kind)
      cau_pkg::OP_MUL: begin
        a_nxt.x_re = 65'(up_word.p_rr) - 65'(up_word.p_ii);
        a_nxt.x_im = 65'(up_word.p_ri) + 65'(up_word.p_ir);
      end
      cau_pkg::OP_DIV: begin
        a_nxt.x_re = 65'(up_word.p_rr) + 65'(up_word.p_ii);
        a_nxt.x_im = 65'(up_word.p_ir) - 65'(up_word.p_ri);
      end
      default: begin
        a_nxt.x_re = 65'(up_word.s_re);
        a_nxt.x_im = 65'(up_word.s_im);
      end
    endcase
  end

  always_comb begin
    abs_re = a_r.x_re[64] ? -a_r.x_re : a_r.x_re;
    abs_im = a_r.x_im[64] ? -a_r.x_im : a_r.x_im;
    rnd_re = abs_re[63:0] + RND;
    rnd_im = abs_im[63:0] + RND;
    b_nxt.div    = (a_r.kind == cau_pkg::OP_DIV);
    b_nxt.dz     = b_nxt.div && (a_r.den == 64'd0);
    b_nxt.neg_re = a_r.x_re[64];
    b_nxt.neg_im = a_r.x_im[64];
    b_nxt.big_re = b_nxt.div && ({32'd0, abs_re[63:32]} >= a_r.den);
    b_nxt.big_im = b_nxt.div && ({32'd0, abs_im[63:32]} >= a_r.den);
    b_nxt.den    = a_r.den;
    if (a_r.kind == cau_pkg::OP_MUL) begin
      b_nxt.mag_re = rnd_re >> FRAC_BITS;
      b_nxt.mag_im = rnd_im >> FRAC_BITS;
    end else begin
      b_nxt.mag_re = abs_re[63:0];
      b_nxt.mag_im = abs_im[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (!stl_a) begin
        va_r <= up_valid;
      end
      if (!stl_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stl_a && up_valid) begin
      a_r <= a_nxt;
    end
    if (!stl_b && va_r) begin
      b_r <= b_nxt;
    end
  end

endmodule

// File: rtl/core/cau_div.sv
`timescale 1ns / 1ps

module cau_div #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 33 + FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_stall,
  input  cau_pkg::mid_t up_word,
  output logic          dn_valid,
  input  logic          dn_stall,
  output cau_pkg::mid_t dn_word,
  output logic [QW-1:0] dn_q_re,
  output logic [QW-1:0] dn_q_im
);

  localparam int NSTEP = QW;

  function automatic logic [64:0] div_step(logic [63:0] r, logic b, logic [63:0] den);
    logic [64:0] t;
    logic [64:0] d;
    t = {r, b};
    d = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, d[63:0]};
    end else begin
      div_step = {1'b0, t[63:0]};
    end
  endfunction

  logic          v_r   [NSTEP];
  cau_pkg::mid_t w_r   [NSTEP];
  logic [63:0]   rre_r [NSTEP];
  logic [63:0]   rim_r [NSTEP];
  logic [QW-1:0] qre_r [NSTEP];
  logic [QW-1:0] qim_r [NSTEP];
  logic [NSTEP:0] stl;

  assign stl[NSTEP] = dn_stall;
  assign up_stall   = stl[0];
  assign dn_valid   = v_r[NSTEP-1];
  assign dn_word    = w_r[NSTEP-1];
  assign dn_q_re    = qre_r[NSTEP-1];
  assign dn_q_im    = qim_r[NSTEP-1];

  for (genvar k = 0; k < NSTEP; k++) begin : g_stage
    logic          in_v;
    cau_pkg::mid_t in_w;
    logic [63:0]   in_rre;
    logic [63:0]   in_rim;
    logic [QW-1:0] in_qre;
    logic [QW-1:0] in_qim;
    logic          bit_re;
    logic          bit_im;
    logic [64:0]   st_re;
    logic [64:0]   st_im;

    assign stl[k] = v_r[k] && stl[k+1];

    if (k == 0) begin : g_head
      assign in_v   = up_valid;
      assign in_w   = up_word;
      assign in_rre = {32'd0, up_word.mag_re[63:32]};
      assign in_rim = {32'd0, up_word.mag_im[63:32]};
      assign in_qre = '0;
      assign in_qim = '0;
    end else begin : g_body
      assign in_v   = v_r[k-1];
      assign in_w   = w_r[k-1];
      assign in_rre = rre_r[k-1];
      assign in_rim = rim_r[k-1];
      assign in_qre = qre_r[k-1];
      assign in_qim = qim_r[k-1];
    end

    if (k < 32) begin : g_int
      assign bit_re = in_w.mag_re[31-k];
      assign bit_im = in_w.mag_im[31-k];
    end else begin : g_frac
      assign bit_re = 1'b0;
      assign bit_im = 1'b0;
    end

    assign st_re = div_step(in_rre, bit_re, in_w.den);
    assign st_im = div_step(in_rim, bit_im, in_w.den);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (!stl[k]) begin
        v_r[k] <= in_v;
      end
    end

    always_ff @(posedge clk) begin
      if (!stl[k] && in_v) begin
        w_r[k]   <= in_w;
        rre_r[k] <= st_re[63:0];
        rim_r[k] <= st_im[63:0];
        qre_r[k] <= {in_qre[QW-2:0], st_re[64]};
        qim_r[k] <= {in_qim[QW-2:0], st_im[64]};
      end
    end
  end

endmodule

// File: rtl/core/cau_out.sv
`timescale 1ns / 1ps
`include "complex_arith_unit_top_assert.svh"

module cau_out #(
  parameter int QW = 49
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_stall,
  input  cau_pkg::mid_t up_word,
  input  logic [QW-1:0] up_q_re,
  input  logic [QW-1:0] up_q_im,
  output logic          dn_valid,
  input  logic          dn_stall,
  output cau_pkg::out_t dn_word
);

  function automatic logic [32:0] sat_part(logic neg, logic [63:0] m, logic big);
    logic [31:0] lo;
    lo = m[31:0];
    if (neg) begin
      if (big || m > 64'h8000_0000) begin
        sat_part = {1'b1, cau_pkg::SAT_MIN};
      end else begin
        sat_part = {1'b0, -lo};
      end
    end else begin
      if (big || m > 64'h7FFF_FFFF) begin
        sat_part = {1'b1, cau_pkg::SAT_MAX};
      end else begin
        sat_part = {1'b0, lo};
      end
    end
  endfunction

  logic          v_r;
  cau_pkg::out_t w_r;
  cau_pkg::out_t w_nxt;
  logic [QW:0]   qs_re;
  logic [QW:0]   qs_im;
  logic [63:0]   m_re;
  logic [63:0]   m_im;
  logic [32:0]   sr_re;
  logic [32:0]   sr_im;

  assign up_stall = v_r && dn_stall;
  assign dn_valid = v_r;
  assign dn_word  = w_r;

  always_comb begin
    qs_re = {1'b0, up_q_re} + {{QW{1'b0}}, 1'b1};
    qs_im = {1'b0, up_q_im} + {{QW{1'b0}}, 1'b1};
    if (up_word.div) begin
      m_re = {{(64-QW){1'b0}}, qs_re[QW:1]};
      m_im = {{(64-QW){1'b0}}, qs_im[QW:1]};
    end else begin
      m_re = up_word.mag_re;
      m_im = up_word.mag_im;
    end
    sr_re = sat_part(up_word.neg_re, m_re, up_word.big_re);
    sr_im = sat_part(up_word.neg_im, m_im, up_word.big_im);
    if (up_word.dz) begin
      w_nxt = '0;
      w_nxt.div_zero = 1'b1;
    end else begin
      w_nxt.res_re   = sr_re[31:0];
      w_nxt.res_im   = sr_im[31:0];
      w_nxt.div_zero = 1'b0;
      w_nxt.overflow = sr_re[32] || sr_im[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!up_stall) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      w_r <= w_nxt;
    end
  end

  `CAU_ASSERT_IMP(a_dz_clear, v_r && w_r.div_zero, w_r.res_re == '0 && w_r.res_im == '0 && !w_r.overflow, "divide by zero word not cleared")
  `CAU_ASSERT_IMP(a_ovf_limit, v_r && w_r.overflow, w_r.res_re == cau_pkg::SAT_MAX || w_r.res_re == cau_pkg::SAT_MIN || w_r.res_im == cau_pkg::SAT_MAX || w_r.res_im == cau_pkg::SAT_MIN, "overflow without a saturated part")
  `CAU_ASSERT_NXT(a_load, up_valid && !up_stall, v_r, "accepted word lost at output register")

endmodule

// File: rtl/core/complex_arith_unit_top.sv
`timescale 1ns / 1ps
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// operands given as signed fixed-point parts with FRAC_BITS fraction bits.
// Input channel: in_valid / in_stall / in_word (kind, a_re, a_im, b_re, b_im).
// Result channel: out_valid / out_stall / out_word (res_re, res_im, div_zero,
// overflow). A word moves when valid is high and stall is low.
// The pipeline is one multiply stage, two combine stages, FRAC_BITS + 33
// restoring divider steps (one quotient bit per stage) and one output
// register. Every kind takes the same path. Throughput is one word per
// cycle while out_stall is low; the divider stages set the depth.
// Results saturate and set overflow; a zero divisor gives a zero result with
// div_zero set. Reset empties the pipeline and drops any word in flight.
// When out_stall is high the final word holds; stages behind it keep filling
// empty slots and in_stall rises only once every stage holds a word.
module complex_arith_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_word
);

  localparam int QW = 33 + FRAC_BITS;

  logic           p_valid;
  logic           p_stall;
  cau_pkg::prod_t p_word;
  logic           c_valid;
  logic           c_stall;
  cau_pkg::mid_t  c_word;
  logic           d_valid;
  logic           d_stall;
  cau_pkg::mid_t  d_word;
  logic [QW-1:0]  d_q_re;
  logic [QW-1:0]  d_q_im;

  cau_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_word  (in_word),
    .dn_valid (p_valid),
    .dn_stall (p_stall),
    .dn_word  (p_word)
  );

  cau_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p_valid),
    .up_stall (p_stall),
    .up_word  (p_word),
    .dn_valid (c_valid),
    .dn_stall (c_stall),
    .dn_word  (c_word)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid),
    .up_stall (c_stall),
    .up_word  (c_word),
    .dn_valid (d_valid),
    .dn_stall (d_stall),
    .dn_word  (d_word),
    .dn_q_re  (d_q_re),
    .dn_q_im  (d_q_im)
  );

  cau_out #(.QW(QW)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d_valid),
    .up_stall (d_stall),
    .up_word  (d_word),
    .up_q_re  (d_q_re),
    .up_q_im  (d_q_im),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_word  (out_word)
  );

endmodule
